// ===== rtl/core/fbpa_pkg.sv =====
// Shared types and constants for the pool allocator.
// No dependencies.
package fbpa_pkg;

  localparam int HOLE_ENTRIES  = 32;
  localparam int BLOCK_ENTRIES = 32;
  localparam int ADDR_WIDTH    = 16;
  localparam int HIDX_W        = $clog2(HOLE_ENTRIES);
  localparam int HCNT_W        = HIDX_W + 1;
  localparam int BIDX_W        = $clog2(BLOCK_ENTRIES);

  localparam logic [ADDR_WIDTH-1:0] POOL_RESET = ADDR_WIDTH'(10000);

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic REG_STRATEGY  = 1'b0;
  localparam logic REG_POOL_SIZE = 1'b1;

  localparam logic STRAT_FIRST = 1'b0;
  localparam logic STRAT_BEST  = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_FIT  = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_ZERO    = 3'd4;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] start;
    logic [ADDR_WIDTH-1:0] len;
  } hole_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== rtl/core/fbpa_hole_cell.sv =====
// One entry of the hole list chain: loads a new hole or takes its upper neighbor.
// Depends on fbpa_pkg.
module fbpa_hole_cell (
  input  logic               clk,
  input  fbpa_pkg::cell_ctl_t ctl,
  input  fbpa_pkg::hole_t    wr,
  input  fbpa_pkg::hole_t    up,
  output fbpa_pkg::hole_t    q
);

  fbpa_pkg::hole_t h;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      h <= up;
    end else if (ctl.load) begin
      h <= wr;
    end
  end

  assign q = h;

endmodule

// ===== rtl/core/first_best_fit_pool_allocator_unit.sv =====
// Top level of the pool allocator: sequencer, block table and hole cell chain.
// Depends on fbpa_pkg and fbpa_hole_cell.
//
// Usage: drive func, prog_id and req_size with start high while busy is low;
// the item is taken at that edge. One result per item appears on status,
// start_addr, freed_bytes and used_bytes for one cycle with done high; the
// receiver cannot stall, so the result must be taken then. busy is low again
// in the done cycle and a new item may start there.
// Steps: zero-size and table-full allocates answer straight from idle. Other
// allocates walk the hole chain one entry a cycle, then decide; first fit stops
// at the first hole that fits. A release walks the block table once (an unknown
// id answers at the end of that walk), then rebuilds the hole list with one
// block-table pass per remaining live block plus one, since the block table has
// a single read port.
// Configuration: wr_en/wr_index/wr_data, to be written only while idle (the
// block does not enforce this). Index 0 is strategy, index 1 is pool_size, which
// reinitializes the pool to one hole (none for size 0). Reset (rst, synchronous):
// first fit, pool of 10000 bytes as one hole, no blocks, used total 0.
module first_best_fit_pool_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [15:0] prog_id,
  input  logic [15:0] req_size,
  input  logic        wr_en,
  input  logic [0:0]  wr_index,
  input  logic [15:0] wr_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [15:0] start_addr,
  output logic [15:0] freed_bytes,
  output logic [15:0] used_bytes
);

  localparam int AW = fbpa_pkg::ADDR_WIDTH;
  localparam int HN = fbpa_pkg::HOLE_ENTRIES;
  localparam int BN = fbpa_pkg::BLOCK_ENTRIES;
  localparam int HW = fbpa_pkg::HIDX_W;
  localparam int CW = fbpa_pkg::HCNT_W;
  localparam int BW = fbpa_pkg::BIDX_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SRCH    = 3'd1;
  localparam logic [2:0] S_DECIDE  = 3'd2;
  localparam logic [2:0] S_REL     = 3'd3;
  localparam logic [2:0] S_RB_SCAN = 3'd4;
  localparam logic [2:0] S_RB_STEP = 3'd5;

  logic [2:0]    state;
  logic          strategy;
  logic [AW-1:0] pool_size;
  logic [CW-1:0] hole_count;
  logic [AW-1:0] used_total;
  logic [BN-1:0] bvalid;
  logic [15:0]   bowner [BN];
  logic [AW-1:0] bstart [BN];
  logic [AW-1:0] blen   [BN];

  logic [15:0]   op_id;
  logic [AW-1:0] op_size;
  logic [BW-1:0] slot;
  logic [CW-1:0] hi;
  logic [BW-1:0] bi;
  logic          found;
  logic [HW-1:0] pick;
  logic [AW-1:0] pick_start;
  logic [AW-1:0] pick_len;
  logic [AW-1:0] freed;
  logic          any_hit;
  logic [AW-1:0] cursor;
  logic          rb_found;
  logic [AW-1:0] rb_start;
  logic [AW-1:0] rb_len;

  fbpa_pkg::hole_t     holes [HN];
  fbpa_pkg::cell_ctl_t ctl   [HN];
  fbpa_pkg::hole_t     hole_wr;
  logic                ld_en;
  logic [HW-1:0]       ld_idx;
  logic                sh_en;

  fbpa_pkg::hole_t hole_rd;
  logic            scan_end;
  logic            fit;
  logic [AW-1:0]   new_len;
  logic            free_any;
  logic [BW-1:0]   free_slot;
  logic            rel_match;
  logic            rb_cand;
  logic [AW-1:0]   rb_end;
  logic            rb_write;
  logic            pool_wr;

  assign pool_wr = wr_en && (wr_index == fbpa_pkg::REG_POOL_SIZE);

  assign hole_rd  = holes[hi[HW-1:0]];
  assign scan_end = (hi == hole_count) || (hi == CW'(HN));
  assign fit      = (hole_rd.len >= op_size) &&
                    (!found || (strategy == fbpa_pkg::STRAT_BEST && hole_rd.len < pick_len));
  assign new_len  = pick_len - op_size;

  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int k = BN - 1; k >= 0; k--) begin
      if (!bvalid[k]) begin
        free_any  = 1'b1;
        free_slot = BW'(k);
      end
    end
  end

  assign rel_match = bvalid[bi] && (bowner[bi] == op_id);
  assign rb_cand   = bvalid[bi] && (bstart[bi] >= cursor) &&
                     (!rb_found || bstart[bi] < rb_start);
  assign rb_end    = rb_found ? rb_start : pool_size;
  assign rb_write  = (rb_end > cursor) && (hole_count < CW'(HN));

  always_comb begin
    ld_en   = 1'b0;
    ld_idx  = '0;
    sh_en   = 1'b0;
    hole_wr = '0;
    if (rst) begin
      ld_en         = 1'b1;
      hole_wr.len   = fbpa_pkg::POOL_RESET;
    end else if (pool_wr) begin
      ld_en         = 1'b1;
      hole_wr.len   = wr_data;
    end else if (state == S_DECIDE && found) begin
      if (new_len == '0) begin
        sh_en = 1'b1;
      end else begin
        ld_en         = 1'b1;
        ld_idx        = pick;
        hole_wr.start = pick_start + op_size;
        hole_wr.len   = new_len;
      end
    end else if (state == S_RB_STEP && rb_write) begin
      ld_en         = 1'b1;
      ld_idx        = hole_count[HW-1:0];
      hole_wr.start = cursor;
      hole_wr.len   = rb_end - cursor;
    end
  end

  for (genvar g = 0; g < HN; g++) begin : g_cell
    assign ctl[g].load  = ld_en && (ld_idx == HW'(g));
    assign ctl[g].shift = sh_en && (HW'(g) >= pick);
    fbpa_hole_cell u_cell (
      .clk (clk),
      .ctl (ctl[g]),
      .wr  (hole_wr),
      .up  ((g == HN - 1) ? fbpa_pkg::hole_t'('0) : holes[(g + 1) % HN]),
      .q   (holes[g])
    );
  end

  always_ff @(posedge clk) begin
    if (state == S_DECIDE && found) begin
      bowner[slot] <= op_id;
      bstart[slot] <= pick_start;
      blen[slot]   <= op_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      strategy   <= fbpa_pkg::STRAT_FIRST;
      pool_size  <= fbpa_pkg::POOL_RESET;
      hole_count <= CW'(1);
      used_total <= '0;
      bvalid     <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        if (wr_index == fbpa_pkg::REG_STRATEGY) begin
          strategy <= wr_data[0];
        end else begin
          pool_size  <= wr_data;
          hole_count <= (wr_data != '0) ? CW'(1) : '0;
          used_total <= '0;
          bvalid     <= '0;
        end
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op_id      <= prog_id;
            op_size    <= req_size;
            slot       <= free_slot;
            hi         <= '0;
            bi         <= '0;
            found      <= 1'b0;
            pick       <= '0;
            pick_start <= '0;
            pick_len   <= '0;
            freed      <= '0;
            any_hit    <= 1'b0;
            if (func == fbpa_pkg::FUNC_RELEASE) begin
              state <= S_REL;
            end else if (req_size == '0) begin
              done       <= 1'b1;
              status     <= fbpa_pkg::ST_ZERO;
              start_addr <= '0;
              freed_bytes <= '0;
              used_bytes <= used_total;
            end else if (!free_any) begin
              done       <= 1'b1;
              status     <= fbpa_pkg::ST_FULL;
              start_addr <= '0;
              freed_bytes <= '0;
              used_bytes <= used_total;
            end else begin
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (scan_end) begin
            state <= S_DECIDE;
          end else begin
            if (fit) begin
              found      <= 1'b1;
              pick       <= hi[HW-1:0];
              pick_start <= hole_rd.start;
              pick_len   <= hole_rd.len;
              if (strategy == fbpa_pkg::STRAT_FIRST) begin
                state <= S_DECIDE;
              end
            end
            hi <= hi + CW'(1);
          end
        end
        S_DECIDE: begin
          state       <= S_IDLE;
          done        <= 1'b1;
          freed_bytes <= '0;
          if (!found) begin
            status     <= fbpa_pkg::ST_NO_FIT;
            start_addr <= '0;
            used_bytes <= used_total;
          end else begin
            status       <= fbpa_pkg::ST_OK;
            start_addr   <= pick_start;
            used_bytes   <= used_total + op_size;
            used_total   <= used_total + op_size;
            bvalid[slot] <= 1'b1;
            if (new_len == '0) begin
              hole_count <= hole_count - CW'(1);
            end
          end
        end
        S_REL: begin
          if (rel_match) begin
            any_hit    <= 1'b1;
            freed      <= freed + blen[bi];
            bvalid[bi] <= 1'b0;
          end
          bi <= bi + BW'(1);
          if (bi == BW'(BN - 1)) begin
            if (!(any_hit || rel_match)) begin
              state       <= S_IDLE;
              done        <= 1'b1;
              status      <= fbpa_pkg::ST_UNKNOWN;
              start_addr  <= '0;
              freed_bytes <= '0;
              used_bytes  <= used_total;
            end else begin
              state      <= S_RB_SCAN;
              hole_count <= '0;
              cursor     <= '0;
              rb_found   <= 1'b0;
              rb_start   <= '0;
              rb_len     <= '0;
            end
          end
        end
        S_RB_SCAN: begin
          if (rb_cand) begin
            rb_found <= 1'b1;
            rb_start <= bstart[bi];
            rb_len   <= blen[bi];
          end
          bi <= bi + BW'(1);
          if (bi == BW'(BN - 1)) begin
            state <= S_RB_STEP;
          end
        end
        S_RB_STEP: begin
          if (rb_write) begin
            hole_count <= hole_count + CW'(1);
          end
          if (!rb_found) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            status      <= fbpa_pkg::ST_OK;
            start_addr  <= '0;
            freed_bytes <= freed;
            used_total  <= (used_total >= freed) ? used_total - freed : '0;
            used_bytes  <= (used_total >= freed) ? used_total - freed : '0;
          end else begin
            state    <= S_RB_SCAN;
            cursor   <= rb_start + rb_len;
            rb_found <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");
  a_rel_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == fbpa_pkg::FUNC_RELEASE) |=> busy)
    else $error("release item did not start a table walk");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    hole_count <= CW'(HN))
    else $error("hole count beyond list depth");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (status <= fbpa_pkg::ST_ZERO))
    else $error("undefined status code");

endmodule

// ===== bench/fbpa_checker.sv =====
// Checker for the pool allocator: watches the item and result channels, predicts
// each result from its own allocator state and compares field by field.
// Depends on fbpa_pkg.
module fbpa_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        func,
  input  logic [15:0] prog_id,
  input  logic [15:0] req_size,
  input  logic        wr_en,
  input  logic [0:0]  wr_index,
  input  logic [15:0] wr_data,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [15:0] start_addr,
  input  logic [15:0] freed_bytes,
  input  logic [15:0] used_bytes,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HN = fbpa_pkg::HOLE_ENTRIES;
  localparam int BN = fbpa_pkg::BLOCK_ENTRIES;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] start_addr;
    logic [15:0] freed;
    logic [15:0] used;
  } alloc_result_t;

  alloc_result_t expected_results[$];

  logic [15:0] free_start[HN];
  logic [15:0] free_len[HN];
  int          free_count;
  logic [15:0] blk_owner[BN];
  logic [15:0] blk_start[BN];
  logic [15:0] blk_len[BN];
  logic        blk_live[BN];
  logic [15:0] used_sum;
  logic        fit_mode;
  logic [15:0] pool_bytes;

  assign pending = expected_results.size();

  task automatic clear_pool();
    for (int i = 0; i < BN; i++) blk_live[i] = 1'b0;
    used_sum = '0;
    free_count = 0;
    if (pool_bytes != 0) begin
      free_start[0] = '0;
      free_len[0] = pool_bytes;
      free_count = 1;
    end
  endtask

  task automatic rebuild_free_list();
    int cursor;
    int stop;
    int pick;
    bit hit;
    cursor = 0;
    free_count = 0;
    forever begin
      hit = 0;
      pick = 0;
      for (int i = 0; i < BN; i++)
        if (blk_live[i] && blk_start[i] >= cursor &&
            (!hit || blk_start[i] < blk_start[pick])) begin
          pick = i;
          hit = 1;
        end
      stop = hit ? int'(blk_start[pick]) : int'(pool_bytes);
      if (stop > cursor && free_count < HN) begin
        free_start[free_count] = 16'(cursor);
        free_len[free_count] = 16'(stop - cursor);
        free_count++;
      end
      if (!hit) break;
      cursor = int'(blk_start[pick]) + int'(blk_len[pick]);
    end
  endtask

  task automatic predict_item(input logic op, input logic [15:0] id, input logic [15:0] sz,
                              output alloc_result_t r);
    int slot;
    int pick;
    bit hit;
    int freed;
    r = '0;
    if (op == fbpa_pkg::FUNC_ALLOC) begin
      slot = BN;
      for (int i = BN - 1; i >= 0; i--) if (!blk_live[i]) slot = i;
      if (sz == 0) r.status = fbpa_pkg::ST_ZERO;
      else if (slot == BN) r.status = fbpa_pkg::ST_FULL;
      else begin
        hit = 0;
        pick = 0;
        for (int i = 0; i < free_count; i++) begin
          if (free_len[i] >= sz &&
              (!hit || (fit_mode == fbpa_pkg::STRAT_BEST && free_len[i] < free_len[pick])))
          begin
            pick = i;
            hit = 1;
            if (fit_mode == fbpa_pkg::STRAT_FIRST) break;
          end
        end
        if (!hit) r.status = fbpa_pkg::ST_NO_FIT;
        else begin
          r.status = fbpa_pkg::ST_OK;
          r.start_addr = free_start[pick];
          free_start[pick] += sz;
          free_len[pick] -= sz;
          if (free_len[pick] == 0) begin
            for (int i = pick; i + 1 < free_count; i++) begin
              free_start[i] = free_start[i+1];
              free_len[i] = free_len[i+1];
            end
            free_count--;
          end
          blk_owner[slot] = id;
          blk_start[slot] = r.start_addr;
          blk_len[slot] = sz;
          blk_live[slot] = 1'b1;
          used_sum += sz;
        end
      end
    end else begin
      hit = 0;
      freed = 0;
      for (int i = 0; i < BN; i++)
        if (blk_live[i] && blk_owner[i] == id) begin
          hit = 1;
          freed += blk_len[i];
          blk_live[i] = 1'b0;
        end
      if (!hit) r.status = fbpa_pkg::ST_UNKNOWN;
      else begin
        r.status = fbpa_pkg::ST_OK;
        r.freed = 16'(freed);
        used_sum = (used_sum >= freed) ? 16'(used_sum - freed) : '0;
        rebuild_free_list();
      end
    end
    r.used = used_sum;
  endtask

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    alloc_result_t r;
    alloc_result_t w;
    if (rst) begin
      fit_mode = fbpa_pkg::STRAT_FIRST;
      pool_bytes = fbpa_pkg::POOL_RESET;
      clear_pool();
      expected_results.delete();
    end else begin
      if (wr_en) begin
        if (wr_index == fbpa_pkg::REG_STRATEGY) fit_mode = wr_data[0];
        else begin
          pool_bytes = wr_data;
          clear_pool();
        end
      end
      if (done) begin
        if (expected_results.size() == 0) report("unexpected result", status, -1);
        else begin
          w = expected_results.pop_front();
          if (status != w.status) report("status", status, w.status);
          if (start_addr != w.start_addr) report("start_addr", start_addr, w.start_addr);
          if (freed_bytes != w.freed) report("freed_bytes", freed_bytes, w.freed);
          if (used_bytes != w.used) report("used_bytes", used_bytes, w.used);
        end
      end
      if (start && !busy) begin
        predict_item(func, prog_id, req_size, r);
        expected_results.push_back(r);
      end
    end
  end
endmodule

// ===== bench/tb_first_best_fit_pool_allocator_unit.sv =====
// Top of the pool allocator bench: clock, reset, register writes and item
// stimulus in bursts; verdict from the failure count of fbpa_checker.
// Depends on fbpa_pkg, fbpa_checker and first_best_fit_pool_allocator_unit.
module tb_first_best_fit_pool_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0, rst = 1;
  logic        start = 0, func = 0, wr_en = 0;
  logic [15:0] prog_id = '0, req_size = '0, wr_data = '0;
  logic [0:0]  wr_index = '0;
  logic        busy, done;
  logic [2:0]  status;
  logic [15:0] start_addr, freed_bytes, used_bytes;
  int          errors, pending, cycles, n_alloc, n_release;

  localparam int CYCLE_LIMIT = 3000000;

  localparam logic OP_ALLOC   = fbpa_pkg::FUNC_ALLOC;
  localparam logic OP_RELEASE = fbpa_pkg::FUNC_RELEASE;
  localparam logic R_STRAT    = fbpa_pkg::REG_STRATEGY;
  localparam logic R_POOL     = fbpa_pkg::REG_POOL_SIZE;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  first_best_fit_pool_allocator_unit dut (.*);

  fbpa_checker chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(input logic op, input logic [15:0] id, input logic [15:0] sz);
    @(negedge clk);
    while (busy) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    func <= op;
    prog_id <= id;
    req_size <= sz;
    @(posedge clk);
    if (op == OP_ALLOC) n_alloc++; else n_release++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    drain();
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic random_items(input int count, input int ids);
    int sent;
    int gap;
    int burst;
    logic [15:0] id;
    logic [15:0] sz;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < count; b++) begin
        id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, ids));
        case ($urandom_range(0, 9))
          0: sz = 16'($urandom);
          1: sz = 16'($urandom_range(0, 3));
          default: sz = 16'($urandom_range(1, 700));
        endcase
        send(($urandom_range(0, 4) == 0) ? OP_RELEASE : OP_ALLOC, id, sz);
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset pool, edges of the fields, table full, unknown id
    send(OP_ALLOC, 16'h0000, 16'd0);
    send(OP_ALLOC, 16'hFFFF, 16'hFFFF);
    send(OP_RELEASE, 16'h1234, 16'hFFFF);
    send(OP_ALLOC, 16'hFFFF, 16'd10000);
    send(OP_ALLOC, 16'h0001, 16'd1);
    send(OP_RELEASE, 16'hFFFF, 16'd0);
    for (int i = 0; i < 17; i++) send(OP_ALLOC, 16'(i % 3), 16'd7);
    write_reg(R_STRAT, 16'(fbpa_pkg::STRAT_BEST));
    write_reg(R_POOL, 16'd1000);
    for (int i = 0; i < 33; i++) send(OP_ALLOC, 16'(i % 2), 16'(i + 1));
    send(OP_RELEASE, 16'h0000, 16'd0);
    send(OP_ALLOC, 16'h0005, 16'd2);
    send(OP_ALLOC, 16'h0005, 16'd1);
    send(OP_RELEASE, 16'h0001, 16'd0);

    write_reg(R_POOL, 16'hFFFF);
    write_reg(R_STRAT, 16'(fbpa_pkg::STRAT_FIRST));
    send(OP_ALLOC, 16'hAAAA, 16'hFFFF);
    send(OP_ALLOC, 16'h5555, 16'd1);
    send(OP_RELEASE, 16'hAAAA, 16'd0);
    random_items(150, 7);
    drain();
    write_reg(R_STRAT, 16'(fbpa_pkg::STRAT_BEST));
    random_items(150, 7);
    write_reg(R_POOL, 16'd1);
    send(OP_ALLOC, 16'h0003, 16'd1);
    send(OP_ALLOC, 16'h0003, 16'd1);
    send(OP_RELEASE, 16'h0003, 16'd0);
    write_reg(R_POOL, 16'd4000);
    random_items(150, 5);
    write_reg(R_STRAT, 16'(fbpa_pkg::STRAT_FIRST));
    write_reg(R_POOL, 16'd10000);
    random_items(130, 9);

    drain();
    repeat (40) @(posedge clk);
    $display("Ran %0d allocates and %0d releases over pools of 1 to 65535 bytes,", n_alloc,
             n_release);
    $display("first and best fit, with table full, no fit, zero size and unknown ids.");
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
